// ===== hw/rtl/dmv_pkg.sv =====
// ----------------------------------------------------------------------------
// dmv_pkg
// shared types, codes and fixed widths of the matrix-vector multiply block
// ----------------------------------------------------------------------------
package dmv_pkg;

   // fixed field widths
   localparam int IN_IDX_W   = 4;
   localparam int OUT_IDX_W  = 4;
   localparam int VALUE_W    = 32;
   localparam int CFG_DIM_W  = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // fraction bits of the fixed point format
   localparam int FRAC_BITS = 16;

   // request opcodes
   localparam logic OP_MATRIX = 1'b0;
   localparam logic OP_VECTOR = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROWS      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TRANSPOSE = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT,
      ST_DRAIN
   } state_type;

   // control that travels with a product through the pipeline
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } pipe_ctl_type;

   // control for one result word
   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [OUT_IDX_W-1:0] index;
   } res_ctl_type;

endpackage

// ===== hw/rtl/dmv_ram.sv =====
// ----------------------------------------------------------------------------
// dmv_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module dmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/dmv_cell.sv =====
// ----------------------------------------------------------------------------
// dmv_cell
// one accumulator cell of the rotating ring, passes its sum to the next cell
// ----------------------------------------------------------------------------
module dmv_cell #(
   parameter int ACC_W = 71
) (
   input  logic                    clock,
   input  logic                    shift_en,
   input  logic signed [ACC_W-1:0] acc_in,
   output logic signed [ACC_W-1:0] acc_out
);

   logic signed [ACC_W-1:0] acc_ff;

   // take the neighbor's partial sum on every ring step
   always_ff @(posedge clock) begin
      if (shift_en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_out = acc_ff;

endmodule

// ===== hw/rtl/dmv_mac.sv =====
// ----------------------------------------------------------------------------
// dmv_mac
// registered multiplier and the adder that feeds the head of the ring
// ----------------------------------------------------------------------------
module dmv_mac #(
   parameter int ELEM_WIDTH = 32,
   parameter int ACC_W      = 71
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dmv_pkg::pipe_ctl_type        ctl_in,
   input  logic signed [ELEM_WIDTH-1:0] mat_elem,
   input  logic signed [ELEM_WIDTH-1:0] vec_elem,
   input  logic signed [ACC_W-1:0]      tail,
   output dmv_pkg::pipe_ctl_type        ctl_out,
   output logic signed [ACC_W-1:0]      head_sum
);
   import dmv_pkg::*;

   logic signed [2*ELEM_WIDTH-1:0] product_in;
   logic signed [2*ELEM_WIDTH-1:0] product_ff;
   logic signed [ACC_W-1:0]        product_ext;
   logic signed [ACC_W-1:0]        feed;
   pipe_ctl_type                   ctl_ff;

   // product stage
   assign product_in = mat_elem * vec_elem;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   // first pass over the inputs starts every sum from zero
   assign product_ext = ACC_W'(product_ff);
   assign feed        = ctl_ff.first ? '0 : tail;
   assign head_sum    = feed + product_ext;
   assign ctl_out     = ctl_ff;

endmodule

// ===== hw/rtl/dmv_round.sv =====
// ----------------------------------------------------------------------------
// dmv_round
// rounds a finished sum to the element format, saturates, registers the word
// ----------------------------------------------------------------------------
module dmv_round #(
   parameter int ACC_W      = 71,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  dmv_pkg::res_ctl_type                    ctl_in,
   input  logic signed [ACC_W-1:0]                 acc,
   output logic                                    valid,
   output logic [dmv_pkg::OUT_IDX_W-1:0]           index,
   output logic signed [dmv_pkg::VALUE_W-1:0]      value,
   output logic                                    saturated,
   output logic                                    last
);
   import dmv_pkg::*;

   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] MAXV = (ACC_W'(1) << (ELEM_WIDTH - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] MINV = ~MAXV;

   logic signed [ACC_W-1:0]      rounded;
   logic                         sat_hi;
   logic                         sat_lo;
   logic signed [ELEM_WIDTH-1:0] elem;

   logic                         valid_ff;
   logic [OUT_IDX_W-1:0]         index_ff;
   logic signed [VALUE_W-1:0]    value_ff;
   logic                         sat_ff;
   logic                         last_ff;

   // add one half, drop the fraction bits, clip to the element range
   always_comb begin
      rounded = (acc + HALF) >>> FRAC_BITS;
      sat_hi  = rounded > MAXV;
      sat_lo  = rounded < MINV;
      if (sat_hi) begin
         elem = MAXV[ELEM_WIDTH-1:0];
      end else if (sat_lo) begin
         elem = MINV[ELEM_WIDTH-1:0];
      end else begin
         elem = rounded[ELEM_WIDTH-1:0];
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      index_ff <= ctl_in.index;
      last_ff  <= ctl_in.last;
      value_ff <= VALUE_W'(elem);
      sat_ff   <= sat_hi | sat_lo;
   end

   assign valid     = valid_ff;
   assign index     = index_ff;
   assign value     = value_ff;
   assign saturated = sat_ff;
   assign last      = last_ff;

endmodule

// ===== hw/rtl/dense_matrix_vector_multiply.sv =====
// ----------------------------------------------------------------------------
// dense_matrix_vector_multiply
// fixed point matrix times vector with a rotating ring of accumulator cells
// ----------------------------------------------------------------------------
// Each request word loads one matrix or vector element. A vector load marked
// last starts the multiply, and busy then stays high until the sums have been
// drained. The input and output lengths n_in and n_out are set by the
// dimension registers and the transpose bit. The single multiplier takes one
// product per cycle from the matrix ram and always sweeps all MAX_DIM
// accumulator cells of the ring for every input element. Results then come
// out back to back, one word per cycle marked by rsp_valid, in index order;
// the receiver cannot hold them off. The stores need no clearing after
// reset, and configuration writes are always ready but must only be
// issued while busy is low.
// ----------------------------------------------------------------------------
module dense_matrix_vector_multiply #(
   parameter int MAX_DIM    = 16,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request words
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_opcode,
   input  logic [dmv_pkg::IN_IDX_W-1:0]         req_row_index,
   input  logic [dmv_pkg::IN_IDX_W-1:0]         req_col_index,
   input  logic [dmv_pkg::IN_IDX_W-1:0]         req_vector_index,
   input  logic signed [dmv_pkg::VALUE_W-1:0]   req_value,
   input  logic                                 req_vector_last,
   // result words
   output logic                                 rsp_valid,
   output logic [dmv_pkg::OUT_IDX_W-1:0]        rsp_out_index,
   output logic signed [dmv_pkg::VALUE_W-1:0]   rsp_out_value,
   output logic                                 rsp_out_saturated,
   output logic                                 rsp_out_last,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dmv_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dmv_pkg::CSR_DATA_W-1:0]       csr_data
);
   import dmv_pkg::*;

   localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int MAT_AW    = 2 * IDX_W;
   localparam int MAT_DEPTH = 1 << MAT_AW;
   localparam int VEC_DEPTH = 1 << IDX_W;
   localparam int ACC_W     = 2 * ELEM_WIDTH + $clog2(MAX_DIM) + 1;

   // clamp a dimension register to 1..MAX_DIM
   function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] r);
      logic [DIM_W-1:0] d;
      if (r == '0) begin
         d = DIM_W'(1);
      end else if (int'(r) > MAX_DIM) begin
         d = DIM_W'(MAX_DIM);
      end else begin
         d = DIM_W'(r);
      end
      return d;
   endfunction

   logic [CFG_DIM_W-1:0]    rows_cfg_ff;
   logic [CFG_DIM_W-1:0]    cols_cfg_ff;
   logic                    transpose_ff;
   logic [DIM_W-1:0]        rows_eff;
   logic [DIM_W-1:0]        cols_eff;
   logic [DIM_W-1:0]        n_in;
   logic [DIM_W-1:0]        n_out;

   logic                    accept;
   logic                    go;
   logic                    mat_we;
   logic                    vec_we;
   logic [MAT_AW-1:0]       mat_waddr;
   logic [MAT_AW-1:0]       mat_raddr;
   logic [ELEM_WIDTH-1:0]   mat_rd;
   logic [ELEM_WIDTH-1:0]   vec_rd;

   state_type               state_ff;
   state_type               state_in;
   logic [IDX_W-1:0]        ii_ff;
   logic [IDX_W-1:0]        ii_in;
   logic [IDX_W-1:0]        jj_ff;
   logic [IDX_W-1:0]        jj_in;
   logic [IDX_W-1:0]        oo_ff;
   logic [IDX_W-1:0]        oo_in;
   logic                    ii_last;
   logic                    jj_last;
   logic                    oo_last;
   logic                    drain;

   pipe_ctl_type            issue_ctl;
   pipe_ctl_type            s1_ctl_ff;
   pipe_ctl_type            mac_ctl;
   res_ctl_type             res_ctl;

   logic signed [ACC_W-1:0] ring [MAX_DIM];
   logic signed [ACC_W-1:0] head_sum;
   logic                    ring_shift;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff  <= CFG_DIM_W'(16);
         cols_cfg_ff  <= CFG_DIM_W'(16);
         transpose_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ROWS:      rows_cfg_ff  <= csr_data[CFG_DIM_W-1:0];
            REG_COLS:      cols_cfg_ff  <= csr_data[CFG_DIM_W-1:0];
            REG_TRANSPOSE: transpose_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign rows_eff = eff_dim(rows_cfg_ff);
   assign cols_eff = eff_dim(cols_cfg_ff);
   assign n_out    = transpose_ff ? cols_eff : rows_eff;
   assign n_in     = transpose_ff ? rows_eff : cols_eff;

   // element loads
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign mat_we    = accept && (req_opcode == OP_MATRIX) &&
                      (int'(req_row_index) < MAX_DIM) && (int'(req_col_index) < MAX_DIM);
   assign vec_we    = accept && (req_opcode == OP_VECTOR) &&
                      (int'(req_vector_index) < MAX_DIM);
   assign go        = accept && (req_opcode == OP_VECTOR) && req_vector_last;
   assign mat_waddr = {IDX_W'(req_row_index), IDX_W'(req_col_index)};

   // product sweep reads, row major store
   assign mat_raddr = transpose_ff ? {jj_ff, ii_ff} : {ii_ff, jj_ff};

   dmv_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (MAT_DEPTH)
   ) u_mat_ram (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (mat_waddr),
      .wr_data (req_value[ELEM_WIDTH-1:0]),
      .rd_addr (mat_raddr),
      .rd_data (mat_rd)
   );

   dmv_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (VEC_DEPTH)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (vec_we),
      .wr_addr (IDX_W'(req_vector_index)),
      .wr_data (req_value[ELEM_WIDTH-1:0]),
      .rd_addr (jj_ff),
      .rd_data (vec_rd)
   );

   // sequencer
   assign ii_last = (ii_ff == IDX_W'(MAX_DIM - 1));
   assign jj_last = ((DIM_W'(jj_ff) + DIM_W'(1)) == n_in);
   assign oo_last = ((DIM_W'(oo_ff) + DIM_W'(1)) == n_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ii_ff     <= '0;
         jj_ff     <= '0;
         oo_ff     <= '0;
         s1_ctl_ff <= '0;
      end else begin
         state_ff  <= state_in;
         ii_ff     <= ii_in;
         jj_ff     <= jj_in;
         oo_ff     <= oo_in;
         s1_ctl_ff <= issue_ctl;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ii_in     = ii_ff;
      jj_in     = jj_ff;
      oo_in     = oo_ff;
      issue_ctl = '0;
      res_ctl   = '0;
      drain     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               state_in = ST_RUN;
               ii_in    = '0;
               jj_in    = '0;
            end
         end
         ST_RUN: begin
            // one product per cycle, every ring cell once per input element
            issue_ctl.valid = 1'b1;
            issue_ctl.first = (jj_ff == '0);
            issue_ctl.last  = ii_last && jj_last;
            if (ii_last) begin
               ii_in = '0;
               jj_in = jj_ff + IDX_W'(1);
               if (jj_last) begin
                  state_in = ST_WAIT;
               end
            end else begin
               ii_in = ii_ff + IDX_W'(1);
            end
         end
         ST_WAIT: begin
            if (mac_ctl.valid && mac_ctl.last) begin
               state_in = ST_DRAIN;
               oo_in    = '0;
            end
         end
         ST_DRAIN: begin
            // finished sums leave the ring tail in index order
            drain         = 1'b1;
            res_ctl.valid = 1'b1;
            res_ctl.last  = oo_last;
            res_ctl.index = OUT_IDX_W'(oo_ff);
            oo_in         = oo_ff + IDX_W'(1);
            if (oo_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // multiplier and ring head
   dmv_mac #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .ACC_W      (ACC_W)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (s1_ctl_ff),
      .mat_elem (mat_rd),
      .vec_elem (vec_rd),
      .tail     (ring[MAX_DIM-1]),
      .ctl_out  (mac_ctl),
      .head_sum (head_sum)
   );

   // accumulator ring
   assign ring_shift = mac_ctl.valid || drain;

   for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
      if (k == 0) begin : g_head
         dmv_cell #(
            .ACC_W (ACC_W)
         ) u_cell (
            .clock    (clock),
            .shift_en (ring_shift),
            .acc_in   (head_sum),
            .acc_out  (ring[k])
         );
      end else begin : g_body
         dmv_cell #(
            .ACC_W (ACC_W)
         ) u_cell (
            .clock    (clock),
            .shift_en (ring_shift),
            .acc_in   (ring[k-1]),
            .acc_out  (ring[k])
         );
      end
   end

   // rounding and result register
   dmv_round #(
      .ACC_W      (ACC_W),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_round (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (res_ctl),
      .acc       (ring[MAX_DIM-1]),
      .valid     (rsp_valid),
      .index     (rsp_out_index),
      .value     (rsp_out_value),
      .saturated (rsp_out_saturated),
      .last      (rsp_out_last)
   );

endmodule

// ===== hw/rtl/dmv_checker.sv =====
// ----------------------------------------------------------------------------
// dmv_checker
// port level checks on the result word sequence of the multiply block
// ----------------------------------------------------------------------------
module dmv_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          req_opcode,
   input logic                          req_vector_last,
   input logic                          rsp_valid,
   input logic [dmv_pkg::OUT_IDX_W-1:0] rsp_out_index,
   input logic                          rsp_out_last
);
   import dmv_pkg::*;

   // a last vector word starts a multiply
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode == OP_VECTOR) && req_vector_last |=> busy)
      else $error("multiply did not start after last vector word");

   // results only come out of a running multiply
   a_rsp_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word while idle");

   // a result vector starts at index zero
   a_first_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> (rsp_out_index == '0))
      else $error("result vector does not start at index zero");

   // words of one vector are back to back with rising index
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_last |=>
         rsp_valid && (rsp_out_index == OUT_IDX_W'($past(rsp_out_index) + 1'b1)))
      else $error("gap or index skip inside a result vector");

   // the last word closes the vector
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_last |=> !rsp_valid)
      else $error("result word after the last one");

endmodule

bind dense_matrix_vector_multiply dmv_checker u_checker (.*);
